// File: rtl/cmq_pkg.sv
// Shared types and codes for the three-class priority message queue.
`default_nettype none
package cmq_pkg;

  // Request kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Enqueue strategies
  typedef enum logic [2:0] {
    STRAT_FIFO        = 3'd0,
    STRAT_LIFO        = 3'd1,
    STRAT_INT_FIFO    = 3'd2,
    STRAT_INT_LIFO    = 3'd3,
    STRAT_BITVEC_FIFO = 3'd4,
    STRAT_BITVEC_LIFO = 3'd5,
    STRAT_LONG_FIFO   = 3'd6,
    STRAT_LONG_LIFO   = 3'd7
  } cmq_strat_e;

  // Priority classes, in service order
  typedef enum logic [1:0] {
    CLS_NEG  = 2'd0,
    CLS_ZERO = 2'd1,
    CLS_POS  = 2'd2
  } cmq_class_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } cmq_status_e;

  localparam int unsigned RANK_BITS = 68;

  // Input item
  typedef struct packed {
    logic        kind;
    logic [2:0]  strategy;
    logic [63:0] priority_value;
    logic [6:0]  priority_bit_count;
    logic [31:0] handle;
  } cmq_in_t;

  // Result item
  typedef struct packed {
    logic [31:0] out_handle;
    logic        out_valid;
    logic [1:0]  status;
    logic [6:0]  queue_length;
    logic [6:0]  max_length;
  } cmq_out_t;

  // Stored entry: rank = {class, has word0, word0, has word1, word1}
  typedef struct packed {
    logic [RANK_BITS-1:0] rank;
    logic [6:0]           kbits;
    logic [32:0]          order;
    logic [31:0]          stamp;
  } cmq_entry_t;

  // Per-cell control
  typedef struct packed {
    logic shift;
    logic load;
    logic clear;
  } cmq_cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/cmq_cell.sv
// One cell of the rotating entry ring.
`default_nettype none
module cmq_cell #(
  parameter int HANDLE_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmq_pkg::cmq_cell_ctrl_t   ctrl_i,
  input  logic                      nbr_used_i,
  input  cmq_pkg::cmq_entry_t       nbr_entry_i,
  input  logic [HANDLE_BITS-1:0]    nbr_handle_i,
  input  cmq_pkg::cmq_entry_t       new_entry_i,
  input  logic [HANDLE_BITS-1:0]    new_handle_i,
  output logic                      used_o,
  output cmq_pkg::cmq_entry_t       entry_o,
  output logic [HANDLE_BITS-1:0]    handle_o
);
  import cmq_pkg::*;

  logic                   used_q, used_d;
  cmq_entry_t             entry_q, entry_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;

  // Pick clear, load, or take the neighbor
  always_comb begin
    used_d   = used_q;
    entry_d  = entry_q;
    handle_d = handle_q;
    if (ctrl_i.clear) begin
      used_d = 1'b0;
    end else if (ctrl_i.load) begin
      used_d   = 1'b1;
      entry_d  = new_entry_i;
      handle_d = new_handle_i;
    end else if (ctrl_i.shift) begin
      used_d   = nbr_used_i;
      entry_d  = nbr_entry_i;
      handle_d = nbr_handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q  <= entry_d;
    handle_q <= handle_d;
  end

  assign used_o   = used_q;
  assign entry_o  = entry_q;
  assign handle_o = handle_q;

endmodule
`default_nettype wire

// File: rtl/three_class_priority_message_queue_unit.sv
// Top level: three-class priority message queue on a rotating ring of cells.
// Usage:
//   Input channel in_valid_i/in_ready_o carries one request item (enqueue or
//   dequeue). Output channel out_valid_o/out_ready_i returns one result item
//   per request, in request order.
//   Entries live in a ring of QUEUE_DEPTH cells that rotates by one cell a
//   cycle during an enqueue wait or a dequeue pass; only the head is inspected.
// Steps from acceptance to result valid:
//   bad strategy, full store, empty dequeue: check, then result staging.
//   enqueue: check, then the ring rotates until a free cell is at the head,
//   which is loaded, then result staging.
//   dequeue: check, then one ring pass finds the bucket, a second pass finds
//   the entry inside it, then the entry is cleared and the result staged.
// One request is worked on at a time; the next is accepted once the result
// is staged in the output register, even if the receiver has not taken it.
// A stalled receiver holds the result; a finished request waits in its last
// state until the output register is free.
// Reset empties the queue and clears the insert counter, length and peak.
`default_nettype none
module three_class_priority_message_queue_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmq_pkg::cmq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cmq_pkg::cmq_out_t out_data_o
);
  import cmq_pkg::*;

  localparam int IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_ENQ  = 7'b0000100,
    S_DQ1  = 7'b0001000,
    S_DQ2  = 7'b0010000,
    S_DQR  = 7'b0100000,
    S_FIN  = 7'b1000000
  } cmq_state_e;

  cmq_state_e             state_q, state_d;
  cmq_in_t                req_q;
  logic [IDXW-1:0]        step_q, step_d;
  logic [31:0]            cnt_q, cnt_d;
  logic [CNTW-1:0]        len_q, len_d, peak_q, peak_d;
  logic                   found1_q, found1_d, found2_q, found2_d;
  logic [RANK_BITS-1:0]   best_rank_q, best_rank_d;
  logic [31:0]            best_stamp_q, best_stamp_d;
  logic [6:0]             best_kbits_q, best_kbits_d;
  logic [32:0]            best_order_q, best_order_d;
  logic [HANDLE_BITS-1:0] best_handle_q, best_handle_d;
  logic [IDXW-1:0]        best_idx_q, best_idx_d;
  cmq_status_e            pend_st_q, pend_st_d;
  logic                   pend_vld_q, pend_vld_d;
  logic                   res_vld_q, res_vld_d;
  cmq_out_t               out_q, out_d;

  // Ring signals
  logic [QUEUE_DEPTH-1:0] used_w;
  cmq_entry_t             entry_w  [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] handle_w [QUEUE_DEPTH];
  cmq_cell_ctrl_t         ctrl_w   [QUEUE_DEPTH];

  cmq_entry_t             new_entry;
  logic [HANDLE_BITS-1:0] new_handle;
  logic [HANDLE_BITS+31:0] hin_ext;
  logic [HANDLE_BITS+31:0] hout_ext;
  logic [CNTW+6:0]        len_ext, peak_ext;
  logic                   bad_req;
  logic [63:0]            key;
  logic [6:0]             kbits;
  cmq_class_e             cls;
  logic                   lifo;
  logic                   head_used;
  cmq_entry_t             head;
  logic                   rotate, load_head, clr_en, last_step, out_free;

  // Build the entry for the latched request
  always_comb begin
    key   = 64'd0;
    kbits = 7'd0;
    cls   = CLS_ZERO;
    case (cmq_strat_e'(req_q.strategy))
      STRAT_FIFO, STRAT_LIFO: begin
        cls = CLS_ZERO;
      end
      STRAT_INT_FIFO, STRAT_INT_LIFO: begin
        key   = {~req_q.priority_value[31], req_q.priority_value[30:0], 32'd0};
        kbits = 7'd32;
        cls   = req_q.priority_value[31] ? CLS_NEG : CLS_POS;
      end
      STRAT_BITVEC_FIFO, STRAT_BITVEC_LIFO: begin
        kbits = req_q.priority_bit_count;
        if (req_q.priority_bit_count == 7'd0) begin
          key = 64'd0;
        end else if (req_q.priority_bit_count <= 7'd32) begin
          key = {req_q.priority_value[63:32], 32'd0};
        end else begin
          key = req_q.priority_value;
        end
        cls = (req_q.priority_bit_count != 7'd0 && req_q.priority_value[63])
              ? CLS_POS : CLS_NEG;
      end
      STRAT_LONG_FIFO, STRAT_LONG_LIFO: begin
        key   = {~req_q.priority_value[63], req_q.priority_value[62:0]};
        kbits = 7'd64;
        cls   = req_q.priority_value[63] ? CLS_NEG : CLS_POS;
      end
      default: begin
        cls = CLS_ZERO;
      end
    endcase
    lifo = req_q.strategy[0];
    new_entry.rank  = {cls, (kbits != 7'd0), key[63:32], (kbits > 7'd32), key[31:0]};
    new_entry.kbits = kbits;
    new_entry.order = lifo ? {1'b0, ~cnt_q} : {1'b1, cnt_q};
    new_entry.stamp = cnt_q;
  end

  assign bad_req =
    ((req_q.strategy == STRAT_LONG_FIFO || req_q.strategy == STRAT_LONG_LIFO) &&
     req_q.priority_bit_count != 7'd64) ||
    ((req_q.strategy == STRAT_BITVEC_FIFO || req_q.strategy == STRAT_BITVEC_LIFO) &&
     req_q.priority_bit_count > 7'd64);

  assign hin_ext    = {{HANDLE_BITS{1'b0}}, req_q.handle};
  assign new_handle = hin_ext[HANDLE_BITS-1:0];
  assign hout_ext   = {32'd0, best_handle_q};
  assign len_ext    = {7'd0, len_q};
  assign peak_ext   = {7'd0, peak_q};

  assign head_used = used_w[0];
  assign head      = entry_w[0];
  assign rotate    = (state_q == S_ENQ && head_used) || state_q == S_DQ1 ||
                     state_q == S_DQ2;
  assign load_head = (state_q == S_ENQ) && !head_used;
  assign clr_en    = (state_q == S_DQR);
  assign last_step = (step_q == IDXW'(QUEUE_DEPTH - 1));
  assign out_free  = !res_vld_q || out_ready_i;

  // Ring of cells, each takes its right neighbor when rotating
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign ctrl_w[g].shift = rotate;
    assign ctrl_w[g].load  = (g == 0) && load_head;
    assign ctrl_w[g].clear = clr_en && (best_idx_q == IDXW'(g));
    cmq_cell #(
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_w[g]),
      .nbr_used_i  (used_w[(g + 1) % QUEUE_DEPTH]),
      .nbr_entry_i (entry_w[(g + 1) % QUEUE_DEPTH]),
      .nbr_handle_i(handle_w[(g + 1) % QUEUE_DEPTH]),
      .new_entry_i (new_entry),
      .new_handle_i(new_handle),
      .used_o      (used_w[g]),
      .entry_o     (entry_w[g]),
      .handle_o    (handle_w[g])
    );
  end

  // Sequence one request through check, ring passes and result staging
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    cnt_d         = cnt_q;
    len_d         = len_q;
    peak_d        = peak_q;
    found1_d      = found1_q;
    found2_d      = found2_q;
    best_rank_d   = best_rank_q;
    best_stamp_d  = best_stamp_q;
    best_kbits_d  = best_kbits_q;
    best_order_d  = best_order_q;
    best_handle_d = best_handle_q;
    best_idx_d    = best_idx_q;
    pend_st_d     = pend_st_q;
    pend_vld_d    = pend_vld_q;
    res_vld_d     = res_vld_q;
    out_d         = out_q;

    if (res_vld_q && out_ready_i) begin
      res_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        pend_vld_d = 1'b0;
        step_d     = '0;
        found1_d   = 1'b0;
        found2_d   = 1'b0;
        if (req_q.kind == KIND_ENQ) begin
          if (bad_req) begin
            pend_st_d = ST_BAD;
            state_d   = S_FIN;
          end else if (len_q >= CNTW'(QUEUE_DEPTH)) begin
            pend_st_d = ST_FULL;
            state_d   = S_FIN;
          end else begin
            state_d = S_ENQ;
          end
        end else begin
          if (len_q == '0) begin
            pend_st_d = ST_EMPTY;
            state_d   = S_FIN;
          end else begin
            state_d = S_DQ1;
          end
        end
      end
      S_ENQ: begin
        // write at the head once it is free
        if (!head_used) begin
          cnt_d     = cnt_q + 32'd1;
          len_d     = len_q + CNTW'(1);
          if (len_q + CNTW'(1) > peak_q) begin
            peak_d = len_q + CNTW'(1);
          end
          pend_st_d = ST_OK;
          state_d   = S_FIN;
        end
      end
      S_DQ1: begin
        // smallest class and key, oldest bucket on a tie
        if (head_used && (!found1_q ||
            {head.rank, head.stamp} < {best_rank_q, best_stamp_q})) begin
          found1_d     = 1'b1;
          best_rank_d  = head.rank;
          best_stamp_d = head.stamp;
          best_kbits_d = head.kbits;
        end
        step_d = step_q + IDXW'(1);
        if (last_step) begin
          step_d  = '0;
          state_d = S_DQ2;
        end
      end
      S_DQ2: begin
        // smallest order inside the chosen bucket
        if (head_used && head.rank == best_rank_q && head.kbits == best_kbits_q &&
            (!found2_q || head.order < best_order_q)) begin
          found2_d      = 1'b1;
          best_order_d  = head.order;
          best_handle_d = handle_w[0];
          best_idx_d    = step_q;
        end
        step_d = step_q + IDXW'(1);
        if (last_step) begin
          step_d  = '0;
          state_d = S_DQR;
        end
      end
      S_DQR: begin
        len_d      = len_q - CNTW'(1);
        pend_st_d  = ST_OK;
        pend_vld_d = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_d.out_handle   = pend_vld_q ? hout_ext[31:0] : 32'd0;
          out_d.out_valid    = pend_vld_q;
          out_d.status       = pend_st_q;
          out_d.queue_length = len_ext[6:0];
          out_d.max_length   = peak_ext[6:0];
          res_vld_d          = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      cnt_q      <= '0;
      len_q      <= '0;
      peak_q     <= '0;
      found1_q   <= 1'b0;
      found2_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      pend_st_q  <= ST_OK;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      cnt_q      <= cnt_d;
      len_q      <= len_d;
      peak_q     <= peak_d;
      found1_q   <= found1_d;
      found2_q   <= found2_d;
      pend_vld_q <= pend_vld_d;
      pend_st_q  <= pend_st_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    best_rank_q   <= best_rank_d;
    best_stamp_q  <= best_stamp_d;
    best_kbits_q  <= best_kbits_d;
    best_order_q  <= best_order_d;
    best_handle_q <= best_handle_d;
    best_idx_q    <= best_idx_d;
    out_q         <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = res_vld_q;
  assign out_data_o  = out_q;

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNTW'(QUEUE_DEPTH))
    else $error("queue length above depth");

  a_peak_ge_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= len_q)
    else $error("peak below current length");

  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_w) == int'(len_q))
    else $error("occupied cells disagree with length");

  a_remove_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DQR |-> found2_q && used_w[best_idx_q])
    else $error("removal without a matched entry");

  a_accept_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_CHK)
    else $error("accepted item not checked");

endmodule
`default_nettype wire
